/* rtl/cdrp_pkg.sv */
// Shared types and constants for the critically damped reference prefilter.
package cdrp_pkg;

  // Field, operand and accumulator widths.
  localparam int DATA_W    = 32;
  localparam int OPND_W    = 33;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int ACC_W     = 52;
  localparam int REG_IDX_W = 2;

  // The reciprocal 1/(1+p) has quotient bits 32 down to 0.
  localparam int DIV_STEPS = 33;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Register indexes of the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_NATURAL_FREQ  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd1;

  // Register values after reset.
  localparam logic [DATA_W-1:0] NATURAL_FREQ_RESET  = 32'd2058874;
  localparam logic [DATA_W-1:0] SAMPLE_PERIOD_RESET = 32'd429497;

  // Operand pairs of the shared multiplier.
  typedef enum logic [3:0] {
    MUL_TN,   // period * natural frequency
    MUL_GG,   // g * g
    MUL_HH,   // h * h
    MUL_GH,   // g * h
    MUL_TG2,  // period * g^2
    MUL_GHN,  // g*h * natural frequency
    MUL_EHS,  // |error| * h^2
    MUL_VKX,  // |velocity| * T g^2
    MUL_EKV,  // |error| * 2 g h wn
    MUL_VG2   // |velocity| * g^2
  } mul_sel_t;

  // What the datapath takes from the product issued in the cycle before.
  typedef enum logic [3:0] {
    CAP_NONE,
    CAP_S,    // divisor 1 + p, and divider start
    CAP_G2,
    CAP_HS,
    CAP_GH,
    CAP_KX,
    CAP_KV,
    CAP_PE,   // position += rnd(|e| * hs / 2^31)
    CAP_PV,   // position += rnd(|v| * kx / 2^32)
    CAP_VE,   // velocity += rnd(|e| * kv / 2^16)
    CAP_VV    // velocity += rnd(|v| * g2 / 2^31)
  } cap_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    mul_sel_t mul;
    cap_sel_t cap;
    logic     div_step;
    logic     acc_init;
    logic     accept;
    logic     update;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bypass;
  } dp_status_t;

endpackage

/* rtl/cdrp_datapath.sv */
// Datapath of the prefilter: registers, shared multiplier, divider and accumulators.
module cdrp_datapath import cdrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic [DATA_W-1:0]    position_command,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output logic [DATA_W-1:0]    filtered_position,
  output logic [DATA_W-1:0]    filtered_velocity
);

  localparam logic [OPND_W-1:0] ONE_Q32 = {1'b1, {(OPND_W-1){1'b0}}};
  localparam logic [47:0] ONE_Q32_S = 48'h0001_0000_0000;
  localparam logic [47:0] DIV_REM_INIT = 48'h0000_8000_0000;
  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-DATA_W){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-DATA_W){1'b1}}, 32'h8000_0000};

  // Configuration and filter state.
  logic [DATA_W-1:0] natural_freq;
  logic [DATA_W-1:0] sample_period;
  logic [DATA_W-1:0] position_state;
  logic [DATA_W-1:0] velocity_state;

  // Per-sample operands.
  logic [DATA_W-1:0] u;
  logic [DATA_W-1:0] e_mag;
  logic              e_neg;

  // Coefficients and divider.
  logic [47:0]       s;
  logic [47:0]       rem;
  logic [OPND_W-1:0] quo;
  logic [OPND_W-1:0] g2;
  logic [31:0]       hs;
  logic [30:0]       gh;
  logic [31:0]       kx;
  logic [31:0]       kv;

  // Multiplier and accumulators.
  logic [PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0] acc_p;
  logic signed [ACC_W-1:0] acc_v;

  logic [OPND_W-1:0]       opa;
  logic [OPND_W-1:0]       opb;
  logic [OPND_W-1:0]       h_full;
  logic [31:0]             h;
  logic [DATA_W-1:0]       vel_neg_val;
  logic [DATA_W-1:0]       vel_mag;
  logic                    vel_neg;
  logic signed [32:0]      diff;
  logic signed [32:0]      diff_neg;
  logic [48:0]             r2;
  logic                    r_ge;
  logic [PROD_W-1:0]       shifted;
  logic                    half;
  logic [ACC_W-2:0]        rnd;
  logic                    term_neg;
  logic signed [ACC_W-1:0] term;

  function automatic logic [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = 32'h7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'h8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  assign status.bypass     = (natural_freq == '0);
  assign filtered_position = position_state;
  assign filtered_velocity = velocity_state;

  // Derived operands: h = 1 - g, velocity magnitude, error against the stored position.
  assign h_full      = ONE_Q32 - quo;
  assign h           = h_full[31:0];
  assign vel_neg     = velocity_state[DATA_W-1];
  assign vel_neg_val = -velocity_state;
  assign vel_mag     = vel_neg ? vel_neg_val : velocity_state;
  assign diff        = {position_command[DATA_W-1], position_command}
                     - {position_state[DATA_W-1], position_state};
  assign diff_neg    = -diff;

  // One restoring division step on the reciprocal.
  assign r2   = {rem, 1'b0};
  assign r_ge = (r2 >= {1'b0, s});

  // Operand selection for the shared multiplier.
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.mul)
      MUL_TN: begin
        opa = {1'b0, sample_period};
        opb = {1'b0, natural_freq};
      end
      MUL_GG: begin
        opa = quo;
        opb = quo;
      end
      MUL_HH: begin
        opa = {1'b0, h};
        opb = {1'b0, h};
      end
      MUL_GH: begin
        opa = quo;
        opb = {1'b0, h};
      end
      MUL_TG2: begin
        opa = {1'b0, sample_period};
        opb = g2;
      end
      MUL_GHN: begin
        opa = {2'b00, gh};
        opb = {1'b0, natural_freq};
      end
      MUL_EHS: begin
        opa = {1'b0, e_mag};
        opb = {1'b0, hs};
      end
      MUL_VKX: begin
        opa = {1'b0, vel_mag};
        opb = {1'b0, kx};
      end
      MUL_EKV: begin
        opa = {1'b0, e_mag};
        opb = {1'b0, kv};
      end
      MUL_VG2: begin
        opa = {1'b0, vel_mag};
        opb = g2;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Rounding of a product term, half away from zero, with the operand's sign applied.
  always_comb begin
    case (cmd.cap)
      CAP_PV: begin
        shifted = prod >> 32;
        half    = prod[31];
      end
      CAP_VE: begin
        shifted = prod >> 16;
        half    = prod[15];
      end
      default: begin
        shifted = prod >> 31;
        half    = prod[30];
      end
    endcase
    rnd      = shifted[ACC_W-2:0] + {{(ACC_W-2){1'b0}}, half};
    term_neg = (cmd.cap == CAP_PE || cmd.cap == CAP_VE) ? e_neg : vel_neg;
    term     = term_neg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
  end

  // Configuration registers and filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      natural_freq   <= NATURAL_FREQ_RESET;
      sample_period  <= SAMPLE_PERIOD_RESET;
      position_state <= '0;
      velocity_state <= '0;
    end else begin
      if (cfg_write && cfg_index == REG_NATURAL_FREQ) begin
        natural_freq <= cfg_data;
      end
      if (cfg_write && cfg_index == REG_SAMPLE_PERIOD) begin
        sample_period <= cfg_data;
      end
      if (cmd.update) begin
        if (status.bypass) begin
          position_state <= u;
          velocity_state <= '0;
        end else begin
          position_state <= sat32(acc_p);
          velocity_state <= sat32(acc_v);
        end
      end
    end
  end

  // Multiplier output register.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(opa) * PROD_W'(opb);
  end

  // Request capture and error magnitude.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      u     <= position_command;
      e_neg <= diff[32];
      e_mag <= diff[32] ? diff_neg[31:0] : diff[31:0];
    end
  end

  // Divider: s = 1 + p, quotient g = floor(2^64 / s).
  always_ff @(posedge clk) begin
    if (cmd.cap == CAP_S) begin
      s   <= ONE_Q32_S + {1'b0, prod[63:17]};
      rem <= DIV_REM_INIT;
      quo <= '0;
    end else if (cmd.div_step) begin
      rem <= r_ge ? 48'(r2 - {1'b0, s}) : r2[47:0];
      quo <= {quo[OPND_W-2:0], r_ge};
    end
  end

  // Coefficient capture from the product register.
  always_ff @(posedge clk) begin
    case (cmd.cap)
      CAP_G2: g2 <= quo[OPND_W-1] ? ONE_Q32 : {1'b0, prod[63:32]};
      CAP_HS: hs <= prod[63:32];
      CAP_GH: gh <= prod[62:32];
      CAP_KX: kx <= prod[63:32];
      CAP_KV: kv <= prod[62:31];
      default: begin
      end
    endcase
  end

  // Position and velocity accumulators.
  always_ff @(posedge clk) begin
    if (cmd.acc_init) begin
      acc_p <= {{(ACC_W-DATA_W){position_state[DATA_W-1]}}, position_state};
      acc_v <= -$signed({{(ACC_W-DATA_W){velocity_state[DATA_W-1]}}, velocity_state});
    end else begin
      case (cmd.cap)
        CAP_PE, CAP_PV: acc_p <= acc_p + term;
        CAP_VE, CAP_VV: acc_v <= acc_v + term;
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/cdrp_ctrl.sv */
// Controller of the prefilter: sequences coefficient updates and per-request arithmetic.
module cdrp_ctrl import cdrp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       command_valid,
  output logic       command_ready,
  output logic       result_valid,
  input  logic       result_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_C_TN,
    S_C_SINIT,
    S_C_DIV,
    S_C_GG,
    S_C_HH,
    S_C_GH,
    S_C_TG2,
    S_C_GHN,
    S_C_KV,
    S_M_EHS,
    S_M_VKX,
    S_M_EKV,
    S_M_VG2,
    S_M_LAST,
    S_FIN
  } state_t;

  state_t           state;
  logic             dirty;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  logic             slot_free;

  assign command_ready = (state == S_IDLE);
  assign accept        = command_valid && command_ready;
  assign slot_free     = !result_valid || result_ready;

  // State, coefficient-stale flag, divider count and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      dirty        <= 1'b1;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      // A writeback into a free slot presents the new result; otherwise a taken result clears.
      if (state == S_FIN && slot_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      // Any register write makes the coefficients stale until the next refresh finishes.
      if (cfg_write) begin
        dirty <= 1'b1;
      end else if (state == S_C_KV) begin
        dirty <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (status.bypass) begin
              state <= S_FIN;
            end else if (dirty) begin
              state <= S_C_TN;
            end else begin
              state <= S_M_EHS;
            end
          end
        end
        S_C_TN:    state <= S_C_SINIT;
        S_C_SINIT: begin
          cnt   <= '0;
          state <= S_C_DIV;
        end
        S_C_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_C_GG;
          end
        end
        S_C_GG:  state <= S_C_HH;
        S_C_HH:  state <= S_C_GH;
        S_C_GH:  state <= S_C_TG2;
        S_C_TG2: state <= S_C_GHN;
        S_C_GHN: state <= S_C_KV;
        S_C_KV:  state <= S_M_EHS;
        S_M_EHS:  state <= S_M_VKX;
        S_M_VKX:  state <= S_M_EKV;
        S_M_EKV:  state <= S_M_VG2;
        S_M_VG2:  state <= S_M_LAST;
        S_M_LAST: state <= S_FIN;
        S_FIN: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Command decode for the datapath.
  always_comb begin
    cmd          = '0;
    cmd.mul      = MUL_TN;
    cmd.cap      = CAP_NONE;
    cmd.accept   = accept;
    cmd.update   = (state == S_FIN) && slot_free;
    cmd.div_step = (state == S_C_DIV);
    cmd.acc_init = (state == S_M_EHS);
    case (state)
      S_C_TN:    cmd.mul = MUL_TN;
      S_C_SINIT: cmd.cap = CAP_S;
      S_C_GG:    cmd.mul = MUL_GG;
      S_C_HH: begin
        cmd.cap = CAP_G2;
        cmd.mul = MUL_HH;
      end
      S_C_GH: begin
        cmd.cap = CAP_HS;
        cmd.mul = MUL_GH;
      end
      S_C_TG2: begin
        cmd.cap = CAP_GH;
        cmd.mul = MUL_TG2;
      end
      S_C_GHN: begin
        cmd.cap = CAP_KX;
        cmd.mul = MUL_GHN;
      end
      S_C_KV:  cmd.cap = CAP_KV;
      S_M_EHS: cmd.mul = MUL_EHS;
      S_M_VKX: begin
        cmd.cap = CAP_PE;
        cmd.mul = MUL_VKX;
      end
      S_M_EKV: begin
        cmd.cap = CAP_PV;
        cmd.mul = MUL_EKV;
      end
      S_M_VG2: begin
        cmd.cap = CAP_VE;
        cmd.mul = MUL_VG2;
      end
      S_M_LAST: cmd.cap = CAP_VV;
      default: begin
      end
    endcase
  end

  // A result only appears out of the writeback state.
  a_valid_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_FIN))
    else $error("result valid rose outside writeback");

  // Writeback with a free slot always presents the result.
  a_fin_presents: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && slot_free) |=> result_valid)
    else $error("writeback did not present a result");

  // An accepted request always starts work.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted request left the controller idle");

  // Coefficients are marked current only at the end of their update.
  a_dirty_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(dirty) |-> $past(state == S_C_KV))
    else $error("coefficients marked current outside update");

endmodule

/* rtl/critically_damped_reference_prefilter_core.sv */
// Top level of the critically damped second-order reference prefilter.
//
//   Channel   Signals                                    Payload
//   command   command_valid / command_ready             position_command
//   result    result_valid / result_ready               filtered_position, filtered_velocity
//   config    cfg_write, cfg_index (0 wn, 1 period)     cfg_data
//
// A request passes through acceptance, the shared multiplier and accumulators, and
// writeback. The first request after reset or after any register write first refreshes
// the coefficients, with the 33-step radix-2 divider for 1/(1+p) plus six multiplier
// passes. With a zero natural frequency a request goes from acceptance straight to
// writeback. A new request is accepted while the previous result still waits; writeback
// stalls until that result is taken. Reset is synchronous and clears the filter state.
module critically_damped_reference_prefilter_core import cdrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 command_valid,
  output logic                 command_ready,
  input  logic [DATA_W-1:0]    position_command,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [DATA_W-1:0]    filtered_position,
  output logic [DATA_W-1:0]    filtered_velocity
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  cdrp_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .command_valid (command_valid),
    .command_ready (command_ready),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .status        (status),
    .cmd           (cmd)
  );

  // Arithmetic and storage.
  cdrp_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .position_command  (position_command),
    .cmd               (cmd),
    .status            (status),
    .filtered_position (filtered_position),
    .filtered_velocity (filtered_velocity)
  );

endmodule
